FILE: src/mqrr_pkg.sv
// Shared constants, types and pointer helpers for the multi-queue dispatcher.
package mqrr_pkg;

	// Sizing of the job rings.
	localparam int NUM_QUEUES  = 4;
	localparam int RING_DEPTH  = 2048;
	localparam int HANDLE_BITS = 32;

	// Derived widths.
	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW  = $clog2(RING_DEPTH);
	localparam int PW1 = PW + 1;
	localparam int AW  = $clog2(NUM_QUEUES * RING_DEPTH);

	// Fixed port field widths.
	localparam int TYPE_W   = 2;
	localparam int HANDLE_W = 32;
	localparam int OCC_W    = 11;

	// Operation codes carried on the mode field.
	localparam logic MODE_SUBMIT  = 1'b0;
	localparam logic MODE_ACQUIRE = 1'b1;

	typedef logic [PW-1:0]          ptr_t;
	typedef logic [HANDLE_BITS-1:0] handle_t;

	// Ring pointer increment with wrap at the ring depth.
	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == ptr_t'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Number of entries held in a ring, given its write and read pointers.
	function automatic logic [OCC_W-1:0] ring_fill(input ptr_t w, input ptr_t r);
		logic [PW:0] d;
		if (w >= r) begin
			d = {1'b0, w} - {1'b0, r};
		end else begin
			d = {1'b0, w} + PW1'(RING_DEPTH) - {1'b0, r};
		end
		return OCC_W'(d);
	endfunction

endpackage

FILE: src/multi_queue_round_robin_dispatch.sv
// Job dispatcher: per-type rings in one shared memory, round-robin or priority acquire.
// An accepted word moves through stage one and then the output register to the output.
// Throughput: one word per unstalled cycle; each does at most one single-port memory access.
// The input stalls only while a result waits in the output register and another in stage one.
// Reset clears all ring pointers, the rotation index and both valid stages at once.
// The job memory is not cleared; only entries that were pushed are ever read back.
module multi_queue_round_robin_dispatch (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [mqrr_pkg::TYPE_W-1:0]      job_type,
	input  logic [mqrr_pkg::HANDLE_W-1:0]    job_handle,
	input  logic                             use_priority,
	input  logic [mqrr_pkg::TYPE_W-1:0]      priority_type,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             success,
	output logic [mqrr_pkg::HANDLE_W-1:0]    out_handle,
	output logic [mqrr_pkg::TYPE_W-1:0]      out_type,
	output logic [mqrr_pkg::OCC_W-1:0]       occupancy
);
	import mqrr_pkg::*;

	typedef struct packed {
		logic              success;
		logic              pop;
		logic [TYPE_W-1:0] out_type;
		logic [OCC_W-1:0]  occupancy;
	} rslt_t;

	// Ring pointers, one pair per queue, and the rotation index.
	ptr_t            wp_q [NUM_QUEUES];
	ptr_t            rp_q [NUM_QUEUES];
	ptr_t            wp_d [NUM_QUEUES];
	ptr_t            rp_d [NUM_QUEUES];
	logic [OCC_W-1:0] occ_lane [NUM_QUEUES];
	logic [QW-1:0]   rot_q;

	logic [NUM_QUEUES-1:0] empty;
	logic [NUM_QUEUES-1:0] full;
	logic [NUM_QUEUES-1:0] push_sel;
	logic [NUM_QUEUES-1:0] pop_sel;

	logic            accept;
	logic            jt_ok;
	logic [QW-1:0]   jt_idx;
	logic            pop_found;
	logic [QW-1:0]   pop_q;
	logic            do_push;
	logic            do_pop;
	logic            rot_adv;
	logic [QW-1:0]   sel_q;
	ptr_t            sel_ptr;
	logic [AW-1:0]   mem_addr;
	logic [OCC_W-1:0] occ_sel;
	rslt_t           rslt_d;

	// Job memory and its registered read port.
	handle_t         mem [NUM_QUEUES * RING_DEPTH];
	handle_t         mem_rdata_s1;

	// Stage one and output register.
	logic            vld_s1;
	rslt_t           rslt_s1;
	logic            advance;
	logic            out_valid_q;
	logic            success_q;
	logic [HANDLE_W-1:0] out_handle_q;
	logic [TYPE_W-1:0]   out_type_q;
	logic [OCC_W-1:0]    occupancy_q;

	// Handshake control.
	assign in_stall = vld_s1 & out_valid_q & out_stall;
	assign advance  = vld_s1 & ~(out_valid_q & out_stall);
	assign accept   = in_valid & ~in_stall;

	// Decode of the addressed type.
	assign jt_ok  = int'(job_type) < NUM_QUEUES;
	assign jt_idx = QW'(job_type);

	// Pick the ring to pop: the prioritized one, or the first non-empty from the rotation.
	always_comb begin
		int unsigned s;
		logic [QW-1:0] q;
		pop_found = 1'b0;
		pop_q     = '0;
		s         = 0;
		q         = '0;
		if (use_priority) begin
			if (int'(priority_type) < NUM_QUEUES) begin
				pop_q     = QW'(priority_type);
				pop_found = ~empty[QW'(priority_type)];
			end
		end else begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				s = int'(rot_q) + i;
				if (s >= NUM_QUEUES) begin
					s = s - NUM_QUEUES;
				end
				q = QW'(s);
				if (!pop_found && !empty[q]) begin
					pop_found = 1'b1;
					pop_q     = q;
				end
			end
		end
	end

	assign do_push = accept & (mode == MODE_SUBMIT) & jt_ok & ~full[jt_idx];
	assign do_pop  = accept & (mode == MODE_ACQUIRE) & pop_found;
	assign rot_adv = accept & (mode == MODE_ACQUIRE) & ~use_priority;

	// Per-queue status, pointer update and fill count after this step.
	for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_lane
		assign empty[g]    = wp_q[g] == rp_q[g];
		assign full[g]     = ptr_inc(wp_q[g]) == rp_q[g];
		assign push_sel[g] = do_push & (jt_idx == QW'(g));
		assign pop_sel[g]  = do_pop & (pop_q == QW'(g));
		assign wp_d[g]     = push_sel[g] ? ptr_inc(wp_q[g]) : wp_q[g];
		assign rp_d[g]     = pop_sel[g] ? ptr_inc(rp_q[g]) : rp_q[g];
		assign occ_lane[g] = ring_fill(wp_d[g], rp_d[g]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				wp_q[g] <= '0;
				rp_q[g] <= '0;
			end else begin
				wp_q[g] <= wp_d[g];
				rp_q[g] <= rp_d[g];
			end
		end
	end

	// Memory address and occupancy of the addressed type.
	always_comb begin
		sel_ptr = '0;
		occ_sel = '0;
		for (int g = 0; g < NUM_QUEUES; g++) begin
			if (push_sel[g]) begin
				sel_ptr = sel_ptr | wp_q[g];
			end
			if (pop_sel[g]) begin
				sel_ptr = sel_ptr | rp_q[g];
			end
			if (jt_ok && (jt_idx == QW'(g))) begin
				occ_sel = occ_sel | occ_lane[g];
			end
		end
	end

	assign sel_q    = (mode == MODE_SUBMIT) ? jt_idx : pop_q;
	assign mem_addr = AW'(sel_q) * AW'(RING_DEPTH) + AW'(sel_ptr);

	// Result fields known at accept time.
	always_comb begin
		rslt_d.success   = (mode == MODE_SUBMIT) ? do_push : pop_found;
		rslt_d.pop       = do_pop;
		rslt_d.out_type  = do_pop ? TYPE_W'(pop_q) : '0;
		rslt_d.occupancy = occ_sel;
	end

	// Job memory: write on push, registered read on pop.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[mem_addr] <= HANDLE_BITS'(job_handle);
		end
		if (do_pop) begin
			mem_rdata_s1 <= mem[mem_addr];
		end
	end

	// Rotation index advances on every non-priority acquire.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q <= '0;
		end else if (rot_adv) begin
			rot_q <= (rot_q == QW'(NUM_QUEUES - 1)) ? '0 : rot_q + 1'b1;
		end
	end

	// Stage one valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rslt_s1 <= rslt_d;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload, with the handle taken from the memory read on a pop.
	always_ff @(posedge clk) begin
		if (advance) begin
			success_q    <= rslt_s1.success;
			out_handle_q <= rslt_s1.pop ? HANDLE_W'(mem_rdata_s1) : '0;
			out_type_q   <= rslt_s1.out_type;
			occupancy_q  <= rslt_s1.occupancy;
		end
	end

	assign out_valid  = out_valid_q;
	assign success    = success_q;
	assign out_handle = out_handle_q;
	assign out_type   = out_type_q;
	assign occupancy  = occupancy_q;

endmodule

FILE: src/mqrr_chk.sv
// Port-level checker for the dispatcher and its bind to the top level.
module mqrr_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             success,
	input logic [mqrr_pkg::HANDLE_W-1:0]    out_handle,
	input logic [mqrr_pkg::TYPE_W-1:0]      out_type,
	input logic [mqrr_pkg::OCC_W-1:0]       occupancy
);
	import mqrr_pkg::*;

	// A failed result word carries neither a handle nor a source type.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !success |-> out_handle == '0 && out_type == '0)
		else $error("failed result word carries a handle or type");

	// A newly valid result word must stem from an accepted input word.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without matching input word");

	// A ring never reports more than its capacity.
	a_occ_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> int'(occupancy) <= RING_DEPTH - 1)
		else $error("occupancy exceeds ring capacity");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(success) && $stable(out_handle)
			&& $stable(out_type) && $stable(occupancy))
		else $error("stalled result word changed");

endmodule

bind multi_queue_round_robin_dispatch mqrr_chk u_mqrr_chk (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the multi-queue round-robin job dispatcher.
module testbench;
	import mqrr_pkg::*;

	// One submit or acquire request as driven on the input channel.
	typedef struct {
		logic                mode;
		logic [TYPE_W-1:0]   jtype;
		logic [HANDLE_W-1:0] handle;
		logic                use_pri;
		logic [TYPE_W-1:0]   pri_type;
	} job_word_t;

	// One result word as seen on the output channel.
	typedef struct {
		logic                success;
		logic [HANDLE_W-1:0] handle;
		logic [TYPE_W-1:0]   src_type;
		logic [OCC_W-1:0]    occ;
	} dispatch_result_t;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic                mode          = MODE_SUBMIT;
	logic [TYPE_W-1:0]   job_type      = '0;
	logic [HANDLE_W-1:0] job_handle    = '0;
	logic                use_priority  = 1'b0;
	logic [TYPE_W-1:0]   priority_type = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic                success;
	logic [HANDLE_W-1:0] out_handle;
	logic [TYPE_W-1:0]   out_type;
	logic [OCC_W-1:0]    occupancy;

	// Shadow copy of the rings and the rotation index.
	logic [HANDLE_W-1:0] ring_mem [NUM_QUEUES][RING_DEPTH];
	int unsigned         wr_idx [NUM_QUEUES];
	int unsigned         rd_idx [NUM_QUEUES];
	int unsigned         rr_start;

	dispatch_result_t    results_due [$];
	int                  mismatch_count;
	bit                  idle_enable;
	int                  long_hold_cycles;

	multi_queue_round_robin_dispatch DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.job_type      (job_type),
		.job_handle    (job_handle),
		.use_priority  (use_priority),
		.priority_type (priority_type),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.success       (success),
		.out_handle    (out_handle),
		.out_type      (out_type),
		.occupancy     (occupancy)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Entries currently held in one shadow ring.
	function automatic int unsigned ring_count(input int unsigned q);
		return (wr_idx[q] + RING_DEPTH - rd_idx[q]) % RING_DEPTH;
	endfunction

	// Pops the oldest handle of ring q into the result, if the ring holds one.
	function automatic bit ring_take(input int unsigned q, inout dispatch_result_t r);
		if (ring_count(q) == 0) begin
			return 1'b0;
		end
		r.success  = 1'b1;
		r.handle   = ring_mem[q][rd_idx[q]];
		r.src_type = TYPE_W'(q);
		rd_idx[q]  = (rd_idx[q] + 1) % RING_DEPTH;
		return 1'b1;
	endfunction

	// Applies one request to the shadow rings and returns the result word it must produce.
	function automatic dispatch_result_t predict_dispatch(input job_word_t w);
		dispatch_result_t r;
		int unsigned      start;
		int unsigned      i;
		r = '{success: 1'b0, handle: '0, src_type: '0, occ: '0};
		if (w.mode == MODE_SUBMIT) begin
			if (ring_count(w.jtype) < RING_DEPTH - 1) begin
				ring_mem[w.jtype][wr_idx[w.jtype]] = w.handle;
				wr_idx[w.jtype] = (wr_idx[w.jtype] + 1) % RING_DEPTH;
				r.success = 1'b1;
			end
		end else if (w.use_pri) begin
			void'(ring_take(w.pri_type, r));
		end else begin
			// Scan from the rotation point; the point moves on whatever the outcome.
			start    = rr_start;
			rr_start = (rr_start + 1) % NUM_QUEUES;
			for (i = 0; i < NUM_QUEUES; i++) begin
				if (ring_take((start + i) % NUM_QUEUES, r)) begin
					break;
				end
			end
		end
		r.occ = OCC_W'(ring_count(w.jtype));
		return r;
	endfunction

	function automatic job_word_t make_word(input logic m, input int unsigned jt,
			input logic [HANDLE_W-1:0] h, input logic up, input int unsigned pt);
		job_word_t w;
		w.mode     = m;
		w.jtype    = TYPE_W'(jt);
		w.handle   = h;
		w.use_pri  = up;
		w.pri_type = TYPE_W'(pt);
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [HANDLE_W-1:0] got,
			input logic [HANDLE_W-1:0] want);
		$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
		mismatch_count++;
	endtask

	// Offers one word, with an occasional random gap first, and waits until it is taken.
	task automatic send_word(input job_word_t w);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= w.mode;
		job_type      <= w.jtype;
		job_handle    <= w.handle;
		use_priority  <= w.use_pri;
		priority_type <= w.pri_type;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		results_due.push_back(predict_dispatch(w));
	endtask

	// Stops offering and waits until every expected result has come out.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (results_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	// Receiver: random stall bursts, calm stretches, and long holds on request.
	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (long_hold_cycles > 0) begin
				n = long_hold_cycles;
				long_hold_cycles = 0;
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_enable && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				out_stall <= 1'b0;
				repeat ($urandom_range(0, 24)) @(posedge clk);
			end
		end
	end

	// Compares every accepted result word with the oldest expectation.
	always @(posedge clk) begin
		dispatch_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				report_mismatch("result word with none expected", out_handle, '0);
			end else begin
				exp_r = results_due.pop_front();
				if (success !== exp_r.success)
					report_mismatch("success", HANDLE_W'(success),
						HANDLE_W'(exp_r.success));
				if (out_handle !== exp_r.handle)
					report_mismatch("out_handle", out_handle, exp_r.handle);
				if (out_type !== exp_r.src_type)
					report_mismatch("out_type", HANDLE_W'(out_type),
						HANDLE_W'(exp_r.src_type));
				if (occupancy !== exp_r.occ)
					report_mismatch("occupancy", HANDLE_W'(occupancy),
						HANDLE_W'(exp_r.occ));
			end
		end
	end

	// Empty rings, field extremes, rotation wrap, priority without rotation.
	task automatic test_directed_cases();
		send_word(make_word(MODE_ACQUIRE, 0, 32'h0, 1'b0, 0));
		send_word(make_word(MODE_ACQUIRE, 3, 32'h0, 1'b1, 3));
		send_word(make_word(MODE_SUBMIT, 0, 32'h0000_0000, 1'b0, 0));
		send_word(make_word(MODE_SUBMIT, 1, 32'hFFFF_FFFF, 1'b1, 3));
		send_word(make_word(MODE_SUBMIT, 3, 32'hAAAA_AAAA, 1'b1, 2));
		send_word(make_word(MODE_SUBMIT, 3, 32'h5555_5555, 1'b0, 1));
		send_word(make_word(MODE_ACQUIRE, 3, 32'hFFFF_FFFF, 1'b0, 3));
		send_word(make_word(MODE_ACQUIRE, 3, 32'h0, 1'b0, 0));
		send_word(make_word(MODE_ACQUIRE, 0, 32'h0, 1'b1, 0));
		send_word(make_word(MODE_ACQUIRE, 0, 32'h0, 1'b1, 0));
		// The rotation point wraps from the last ring back to the first.
		send_word(make_word(MODE_ACQUIRE, 2, 32'h0, 1'b0, 2));
		send_word(make_word(MODE_ACQUIRE, 1, 32'h0, 1'b0, 1));
		send_word(make_word(MODE_SUBMIT, 2, 32'h1234_5678, 1'b0, 0));
		send_word(make_word(MODE_SUBMIT, 2, 32'h8000_0001, 1'b0, 0));
		send_word(make_word(MODE_ACQUIRE, 1, 32'h0, 1'b1, 2));
		send_word(make_word(MODE_ACQUIRE, 2, 32'h0, 1'b1, 1));
		send_word(make_word(MODE_ACQUIRE, 2, $urandom, 1'b0, 3));
		send_word(make_word(MODE_SUBMIT, 0, $urandom, 1'b0, 0));
		send_word(make_word(MODE_ACQUIRE, 0, 32'h0, 1'b0, 0));
		wait_drain();
	endtask

	// Holds the output off for a long time while words keep coming, so the input stalls.
	task automatic test_output_hold();
		int k;
		long_hold_cycles = 80;
		// Start sending only once the receiver has begun the hold.
		while (long_hold_cycles != 0) begin
			@(posedge clk);
		end
		for (k = 0; k < 24; k++) begin
			send_word(make_word(k % 3 == 2 ? MODE_ACQUIRE : MODE_SUBMIT,
				$urandom_range(0, 3), $urandom, 1'($urandom), $urandom));
		end
		wait_drain();
	endtask

	// Random traffic in batches whose submit share swings so rings grow and shrink.
	task automatic test_random_traffic(input int n_words);
		job_word_t w;
		int        bias;
		int        k;
		for (k = 0; k < n_words; k++) begin
			if (k % 50 == 0) begin
				bias = $urandom_range(25, 75);
			end
			if (k == n_words - 150) begin
				idle_enable = 1'b0;
			end
			w.mode     = ($urandom_range(0, 99) < bias) ? MODE_SUBMIT : MODE_ACQUIRE;
			w.jtype    = TYPE_W'($urandom);
			w.handle   = $urandom;
			w.use_pri  = ($urandom_range(0, 3) == 0);
			w.pri_type = TYPE_W'($urandom);
			send_word(w);
		end
		wait_drain();
	endtask

	initial begin
		mismatch_count   = 0;
		long_hold_cycles = 0;
		idle_enable      = 1'b1;
		rr_start         = 0;
		foreach (wr_idx[q]) begin
			wr_idx[q] = 0;
			rd_idx[q] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_output_hold();
		test_random_traffic(1300);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
